### design/wildcard_byte_pattern_scan_top_macros.svh
// Assertion macros shared by the scan block's RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_TOP_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_TOP_MACROS_SVH

// Same-cycle implication, checked on i_clk with i_rst_n as the reset.
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk with i_rst_n as the reset.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wbps_pkg.sv
// Package for the wildcard byte pattern scanner: constants, register codes and types.
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF       = 32;

    localparam int CFG_INDEX_BITS    = 8;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CARE_BITS         = 16;
    localparam int LENGTH_BITS       = 5;
    localparam int MATCH_OFFSET_BITS = 32;

    localparam logic [CFG_DATA_BITS-1:0] PATTERN_RESET = '0;
    localparam logic [CARE_BITS-1:0]     CARE_RESET    = '1;
    localparam logic [LENGTH_BITS-1:0]   LENGTH_RESET  = LENGTH_BITS'(1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LOW    = CFG_INDEX_BITS'(0),
        REG_PATTERN_HIGH   = CFG_INDEX_BITS'(1),
        REG_CARE_MASK      = CFG_INDEX_BITS'(2),
        REG_PATTERN_LENGTH = CFG_INDEX_BITS'(3)
    } t_cfg_reg;

    typedef struct packed {
        logic                         found;
        logic [MATCH_OFFSET_BITS-1:0] match_offset;
    } t_result;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

`default_nettype wire

### design/wbps_ifs.sv
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none

interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [wbps_pkg::MATCH_OFFSET_BITS-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wbps_pkg::CFG_INDEX_BITS-1:0] index;
    logic [wbps_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/wbps_cell.sv
// One cell of the shift-and chain: holds one partial-match bit and one pattern byte compare.
`default_nettype none

module wbps_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wbps_pkg::t_cell_ctl     i_ctl,
    input  wire                     i_prev,
    input  wire  [7:0]              i_data,
    input  wire  [7:0]              i_pattern,
    input  wire                     i_care,
    output logic                    o_next,
    output logic                    o_bit
);

    logic r_bit;
    logic n_bit;

    // The bit survives when the neighbor matched one byte earlier and this byte fits.
    assign n_bit  = i_prev & (~i_care | (i_pattern == i_data));
    assign o_next = n_bit;
    assign o_bit  = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.advance) begin
            r_bit <= i_ctl.clear ? 1'b0 : n_bit;
        end
    end

endmodule

`default_nettype wire

### design/wbps_outbuf.sv
// Two-entry result buffer: an output register backed by one skid entry.
`default_nettype none

module wbps_outbuf (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wbps_pkg::t_result        i_word,
    output wbps_pkg::t_buf_status    o_status,
    output logic                     o_valid,
    input  wire                      i_ready,
    output wbps_pkg::t_result        o_word
);

    logic              r_main_valid;
    logic              r_skid_valid;
    wbps_pkg::t_result r_main;
    wbps_pkg::t_result r_skid;
    logic              pop;

    assign pop      = r_main_valid & i_ready;
    assign o_valid  = r_main_valid;
    assign o_word   = r_main;
    assign o_status = '{main_valid: r_main_valid, skid_valid: r_skid_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No push can arrive while the skid entry is full.
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_word;
            end else begin
                r_skid <= i_word;
            end
        end
    end

endmodule

`default_nettype wire

### design/wildcard_byte_pattern_scan_top.sv
// Top level of the wildcard byte pattern scanner: config registers, cell chain, offset tracking.
// Throughput: one byte per cycle unless the skid entry is full; the cell chain updates every partial match in parallel.
// On the last byte, the result word is registered in the output register or, behind it, in the skid entry.
// A two-entry result buffer lets bytes keep flowing while one result waits at the output.
// Reset (synchronous, active low) restores the register defaults and clears the scan state.
`default_nettype none
`include "wildcard_byte_pattern_scan_top_macros.svh"

module wildcard_byte_pattern_scan_top #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    wbps_in_if.sink    i_in,
    wbps_out_if.source o_out,
    wbps_cfg_if.sink   i_cfg
);

    localparam int LEN_IDX_W = $clog2(MAX_PATTERN_BYTES);

    logic [wbps_pkg::CFG_DATA_BITS-1:0] r_pattern_low;
    logic [wbps_pkg::CFG_DATA_BITS-1:0] r_pattern_high;
    logic [wbps_pkg::CARE_BITS-1:0]     r_care;
    logic [wbps_pkg::LENGTH_BITS-1:0]   r_length;

    logic [OFFSET_BITS-1:0] r_offset;
    logic [OFFSET_BITS-1:0] r_first;
    logic                   r_seen;

    logic                          accept;
    logic                          push;
    logic [wbps_pkg::LENGTH_BITS-1:0] eff_len;
    logic [LEN_IDX_W-1:0]          len_m1;
    logic [MAX_PATTERN_BYTES-1:0]  chain_bit;
    logic [MAX_PATTERN_BYTES-1:0]  chain_next;
    logic [MAX_PATTERN_BYTES-1:0]  chain_prev;
    logic                          saturated;
    logic                          hit;
    logic [OFFSET_BITS-1:0]        start_offset;
    wbps_pkg::t_cell_ctl           cell_ctl;
    wbps_pkg::t_result             result;
    wbps_pkg::t_result             out_word;
    wbps_pkg::t_buf_status         buf_status;

    // Configuration registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= wbps_pkg::PATTERN_RESET;
            r_pattern_high <= wbps_pkg::PATTERN_RESET;
            r_care         <= wbps_pkg::CARE_RESET;
            r_length       <= wbps_pkg::LENGTH_RESET;
        end else if (i_cfg.valid) begin
            case (wbps_pkg::t_cfg_reg'(i_cfg.index))
                wbps_pkg::REG_PATTERN_LOW: begin
                    r_pattern_low <= i_cfg.data;
                end
                wbps_pkg::REG_PATTERN_HIGH: begin
                    r_pattern_high <= i_cfg.data;
                end
                wbps_pkg::REG_CARE_MASK: begin
                    r_care <= i_cfg.data[wbps_pkg::CARE_BITS-1:0];
                end
                wbps_pkg::REG_PATTERN_LENGTH: begin
                    r_length <= i_cfg.data[wbps_pkg::LENGTH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A length of zero acts as one; anything above the chain length is clipped.
    always_comb begin
        if (r_length == '0) begin
            eff_len = wbps_pkg::LENGTH_BITS'(1);
        end else if (r_length > wbps_pkg::LENGTH_BITS'(MAX_PATTERN_BYTES)) begin
            eff_len = wbps_pkg::LENGTH_BITS'(MAX_PATTERN_BYTES);
        end else begin
            eff_len = r_length;
        end
    end

    assign len_m1 = LEN_IDX_W'(eff_len - wbps_pkg::LENGTH_BITS'(1));

    assign i_in.ready = ~buf_status.skid_valid;
    assign accept     = i_in.valid & i_in.ready;
    assign push       = accept & i_in.last_byte;
    assign cell_ctl   = '{advance: accept, clear: i_in.last_byte};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN_BYTES; gi++) begin : g_cell
            logic [7:0] pattern_byte;

            if (gi == 0) begin : g_head
                assign chain_prev[gi] = 1'b1;
            end else begin : g_link
                assign chain_prev[gi] = chain_bit[gi-1];
            end

            if (gi < 8) begin : g_low
                assign pattern_byte = r_pattern_low[gi*8 +: 8];
            end else begin : g_high
                assign pattern_byte = r_pattern_high[(gi-8)*8 +: 8];
            end

            wbps_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (cell_ctl),
                .i_prev    (chain_prev[gi]),
                .i_data    (i_in.data_byte),
                .i_pattern (pattern_byte),
                .i_care    (r_care[gi]),
                .o_next    (chain_next[gi]),
                .o_bit     (chain_bit[gi])
            );
        end
    endgenerate

    // A byte at the saturated offset can complete no match.
    assign saturated    = &r_offset;
    assign hit          = ~saturated & ~r_seen & chain_next[len_m1];
    assign start_offset = r_offset - OFFSET_BITS'(len_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_first  <= '0;
            r_seen   <= 1'b0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_offset <= '0;
                r_first  <= '0;
                r_seen   <= 1'b0;
            end else begin
                if (hit) begin
                    r_seen  <= 1'b1;
                    r_first <= start_offset;
                end
                if (!saturated) begin
                    r_offset <= r_offset + OFFSET_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        result.found = r_seen | hit;
        if (r_seen) begin
            result.match_offset = wbps_pkg::MATCH_OFFSET_BITS'(r_first);
        end else if (hit) begin
            result.match_offset = wbps_pkg::MATCH_OFFSET_BITS'(start_offset);
        end else begin
            result.match_offset = '0;
        end
    end

    wbps_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (result),
        .o_status (buf_status),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_word   (out_word)
    );

    assign o_out.found        = out_word.found;
    assign o_out.match_offset = out_word.match_offset;

    `WBPS_ASSERT_NOW(a_no_offset_without_match, o_out.valid && !o_out.found, o_out.match_offset == '0, "match offset set on a result without a match")
    `WBPS_ASSERT_NOW(a_skid_behind_main, buf_status.skid_valid, buf_status.main_valid, "skid entry full while the output register is empty")
    `WBPS_ASSERT_NEXT(a_last_gives_result, accept && i_in.last_byte, o_out.valid, "no result word after the last byte of a region")
    `WBPS_ASSERT_NOW(a_first_not_ahead, r_seen, r_first <= r_offset, "recorded match start lies beyond the current offset")

endmodule

`default_nettype wire
